### sv/uer_pkg.sv
package uer_pkg;

	localparam int TRIG_W    = 10;
	localparam int TIMEOUT_W = 18;
	localparam int HOLD_W    = 20;
	localparam int SPEED_W   = 9;
	localparam int DIST_W    = 16;
	localparam int STATUS_W  = 2;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;

	localparam int COUNT_WIDTH_DEF = 18;

	localparam logic [TRIG_W-1:0]    TRIG_RST    = TRIG_W'(10);
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(100000);
	localparam logic [HOLD_W-1:0]    HOLD_RST    = HOLD_W'(60000);
	localparam logic [SPEED_W-1:0]   SPEED_RST   = SPEED_W'(340);

	localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(40000);
	localparam int                REM_W    = 11;
	localparam logic [REM_W:0]    DIV_DEN  = (REM_W + 1)'(2000);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_TRIG,
		PH_WAIT,
		PH_ECHO
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_TOO_SOON,
		ST_TIMEOUT
	} status_t;

	typedef enum logic [1:0] {
		REG_TRIGGER,
		REG_TIMEOUT,
		REG_HOLDOFF,
		REG_SPEED
	} reg_idx_t;

	typedef struct packed {
		logic [TRIG_W-1:0]    trigger_ticks;
		logic [TIMEOUT_W-1:0] timeout_ticks;
		logic [HOLD_W-1:0]    holdoff_ticks;
		logic [SPEED_W-1:0]   sound_speed;
	} cfg_t;

	typedef struct packed {
		logic                trigger_out;
		logic                busy_res;
		logic                done_res;
		status_t             status;
		logic [DIST_W-1:0]   distance_mm;
	} res_t;

endpackage

### sv/uer_regs.sv
module uer_regs
	import uer_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_ticks <= TRIG_RST;
			cfg_q.timeout_ticks <= TIMEOUT_RST;
			cfg_q.holdoff_ticks <= HOLD_RST;
			cfg_q.sound_speed   <= SPEED_RST;
		end else if (wr) begin
			unique case (idx)
				REG_TRIGGER: cfg_q.trigger_ticks <= pwdata[TRIG_W-1:0];
				REG_TIMEOUT: cfg_q.timeout_ticks <= pwdata[TIMEOUT_W-1:0];
				REG_HOLDOFF: cfg_q.holdoff_ticks <= pwdata[HOLD_W-1:0];
				REG_SPEED:   cfg_q.sound_speed   <= pwdata[SPEED_W-1:0];
				default:     cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_TRIGGER: prdata = DATA_W'(cfg_q.trigger_ticks);
			REG_TIMEOUT: prdata = DATA_W'(cfg_q.timeout_ticks);
			REG_HOLDOFF: prdata = DATA_W'(cfg_q.holdoff_ticks);
			REG_SPEED:   prdata = DATA_W'(cfg_q.sound_speed);
			default:     prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

### sv/uer_tick.sv
module uer_tick
	import uer_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic req,
	input  logic echo,
	input  cfg_t cfg,
	output res_t res
);

	localparam int CMP_W = (COUNT_WIDTH > TIMEOUT_W) ? COUNT_WIDTH : TIMEOUT_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

	phase_t                  phase_q, phase_d;
	logic [COUNT_WIDTH-1:0]  pc_q, pc_d, pc_base, pc_inc;
	logic [COUNT_WIDTH-1:0]  ec_q, ec_d;
	logic [HOLD_W-1:0]       hold_q, hold_d, hold_inc;
	logic                    echo_prev_q;
	logic [REM_W-1:0]        rem_q, rem_d, rem_next;
	logic [DIST_W-1:0]       quo_q, quo_d, quo_next;
	logic [REM_W:0]          rem_sum;
	logic                    rem_wrap, ec_sat;

	logic rise, fall, allowed, start, refuse;
	logic trig_cont, trig_end, in_wait, in_echo, fall_done, timeout;

	assign hold_inc  = (&hold_q) ? hold_q : hold_q + HOLD_W'(1);
	assign rise      = echo & ~echo_prev_q;
	assign fall      = ~echo & echo_prev_q;
	assign allowed   = hold_inc >= cfg.holdoff_ticks;
	assign start     = (phase_q == PH_IDLE) & req & allowed;
	assign refuse    = (phase_q == PH_IDLE) & req & ~allowed;

	assign trig_cont = (phase_q == PH_TRIG) &
		(pc_q < {{(COUNT_WIDTH-TRIG_W){1'b0}}, cfg.trigger_ticks});
	assign trig_end  = (phase_q == PH_TRIG) & ~trig_cont;
	assign in_wait   = (phase_q == PH_WAIT) | trig_end;
	assign in_echo   = (phase_q == PH_ECHO);

	assign pc_base   = trig_end ? '0 : pc_q;
	assign pc_inc    = (&pc_base) ? pc_base : pc_base + CNT_ONE;

	assign fall_done = in_echo & fall;
	assign timeout   = ~fall_done & (in_wait | in_echo) &
		((CMP_W'(pc_inc) >= CMP_W'(cfg.timeout_ticks)) | (&pc_inc));

	// running quotient of echo ticks times speed over the round-trip divisor
	assign ec_sat   = &ec_q;
	assign rem_sum  = {1'b0, rem_q} + (REM_W + 1)'(cfg.sound_speed);
	assign rem_wrap = ~ec_sat & (rem_sum >= DIV_DEN);
	assign rem_next = ec_sat ? rem_q :
		(rem_wrap ? REM_W'(rem_sum - DIV_DEN) : rem_sum[REM_W-1:0]);
	assign quo_next = (rem_wrap && quo_q <= DIST_MAX) ? quo_q + DIST_W'(1) : quo_q;

	always_comb begin
		unique case (phase_q)
			PH_IDLE: phase_d = start ? PH_TRIG : PH_IDLE;
			PH_TRIG: begin
				if (trig_cont)    phase_d = PH_TRIG;
				else if (timeout) phase_d = PH_IDLE;
				else if (rise)    phase_d = PH_ECHO;
				else              phase_d = PH_WAIT;
			end
			PH_WAIT: begin
				if (timeout)   phase_d = PH_IDLE;
				else if (rise) phase_d = PH_ECHO;
				else           phase_d = PH_WAIT;
			end
			PH_ECHO: phase_d = (fall_done | timeout) ? PH_IDLE : PH_ECHO;
			default: phase_d = PH_IDLE;
		endcase
	end

	always_comb begin
		hold_d = start ? '0 : hold_inc;
		if (start)
			pc_d = CNT_ONE;
		else if (phase_q != PH_IDLE)
			pc_d = pc_inc;
		else
			pc_d = pc_q;

		ec_d  = ec_q;
		rem_d = rem_q;
		quo_d = quo_q;
		if (start || (in_wait && rise)) begin
			ec_d  = '0;
			rem_d = '0;
			quo_d = '0;
		end else if (in_echo) begin
			ec_d  = ec_sat ? ec_q : ec_q + CNT_ONE;
			rem_d = rem_next;
			quo_d = quo_next;
		end

		res.trigger_out = start | trig_cont;
		res.busy_res    = (phase_d != PH_IDLE);
		res.done_res    = refuse | fall_done | timeout;
		if (refuse)
			res.status = ST_TOO_SOON;
		else if (timeout)
			res.status = ST_TIMEOUT;
		else
			res.status = ST_OK;
		if (fall_done)
			res.distance_mm = (quo_next > DIST_MAX) ? DIST_MAX : quo_next;
		else
			res.distance_mm = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			pc_q        <= '0;
			ec_q        <= '0;
			hold_q      <= '1;
			echo_prev_q <= 1'b0;
			rem_q       <= '0;
			quo_q       <= '0;
		end else if (en) begin
			phase_q     <= phase_d;
			pc_q        <= pc_d;
			ec_q        <= ec_d;
			hold_q      <= hold_d;
			echo_prev_q <= echo;
			rem_q       <= rem_d;
			quo_q       <= quo_d;
		end
	end

endmodule

### sv/ultrasonic_echo_ranger.sv
// Pulse-echo range finder. Each input word is one microsecond tick carrying a
// measurement request and the sampled echo level; each tick yields exactly one
// result word (trigger level, busy, done, status, distance). The block takes
// one word per clock while the output is not stalled by out_ready, and each
// word passes through the input register, then the result register, before
// its result appears. Distance is kept as a running quotient updated on every
// echo tick, so no multiplier or divider is used. Registers sit on the APB
// port at byte offsets 0, 4, 8 and 12 and are to be written only while idle.
module ultrasonic_echo_ranger
	import uer_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              start_request,
	input  logic              echo_level,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              trigger_out,
	output logic              busy_res,
	output logic              done_res,
	output logic [STATUS_W-1:0] status,
	output logic [DIST_W-1:0] distance_mm
);

	cfg_t cfg;
	res_t res, res_q;
	logic valid_s1, req_s1, echo_s1;
	logic out_valid_q, advance;

	uer_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	uer_tick #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_tick (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.req    (req_s1),
		.echo   (echo_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign pready   = 1'b1;
	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1  <= start_request;
			echo_s1 <= echo_level;
		end
		if (advance)
			res_q <= res;
	end

	assign out_valid   = out_valid_q;
	assign trigger_out = res_q.trigger_out;
	assign busy_res    = res_q.busy_res;
	assign done_res    = res_q.done_res;
	assign status      = res_q.status;
	assign distance_mm = res_q.distance_mm;

endmodule

### sv/uer_checker.sv
module uer_checker
	import uer_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic                trigger_out,
	input logic                busy_res,
	input logic                done_res,
	input logic [STATUS_W-1:0] status,
	input logic [DIST_W-1:0]   distance_mm
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(distance_mm) && $stable(status))
		else $error("result word changed while stalled");

	a_trig_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && trigger_out |-> busy_res && !done_res)
		else $error("trigger driven outside a measurement");

	a_dist_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (!done_res || status != ST_OK) |-> distance_mm == '0)
		else $error("distance reported without a good measurement");

	a_dist_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> distance_mm <= DIST_MAX)
		else $error("distance above range limit");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.trigger_out (trigger_out),
	.busy_res    (busy_res),
	.done_res    (done_res),
	.status      (status),
	.distance_mm (distance_mm)
);
